// ===== rtl/windowed_integrator_debouncer_top_assert.svh =====
// assertion macros shared by the debouncer checker
`ifndef WINDOWED_INTEGRATOR_DEBOUNCER_TOP_ASSERT_SVH
`define WINDOWED_INTEGRATOR_DEBOUNCER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define WID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define WID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wid_pkg.sv =====
`default_nettype none
package wid_pkg;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] TARGET_RST = 8'd6;
    localparam logic [CFG_DATA_W-1:0] WINDOW_RST = 8'd15;

    typedef struct packed {
        logic pressed_event;
        logic released_event;
        logic keep_sampling;
        logic window_expired;
        logic btn_down;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/wid_cfg.sv =====
`default_nettype none
module wid_cfg
    import wid_pkg::*;
#(
    parameter int COUNTER_BITS = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic      [COUNTER_BITS-1:0] o_target,
    output logic      [COUNTER_BITS-1:0] o_window
);

    logic [CFG_DATA_W-1:0] r_target;
    logic [CFG_DATA_W-1:0] r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_window <= WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TARGET: r_target <= i_cfg_wdata;
                REG_WINDOW: r_window <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // saturate the register values to what the counters can hold
    generate
        if (COUNTER_BITS >= CFG_DATA_W) begin : g_wide
            assign o_target = COUNTER_BITS'(r_target);
            assign o_window = COUNTER_BITS'(r_window);
        end else begin : g_narrow
            localparam logic [CFG_DATA_W-1:0] CMAX = CFG_DATA_W'((1 << COUNTER_BITS) - 1);
            assign o_target = (r_target > CMAX) ? CMAX[COUNTER_BITS-1:0]
                                                : r_target[COUNTER_BITS-1:0];
            assign o_window = (r_window > CMAX) ? CMAX[COUNTER_BITS-1:0]
                                                : r_window[COUNTER_BITS-1:0];
        end
    endgenerate

endmodule
`default_nettype wire

// ===== rtl/wid_core.sv =====
`default_nettype none
module wid_core
    import wid_pkg::*;
#(
    parameter int COUNTER_BITS = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire logic                    i_level,
    input  wire logic [COUNTER_BITS-1:0] i_target,
    input  wire logic [COUNTER_BITS-1:0] i_window,
    output t_result                      o_result
);

    logic [COUNTER_BITS-1:0] r_integ;
    logic [COUNTER_BITS-1:0] r_window;
    logic                    r_state;
    logic [COUNTER_BITS-1:0] n_integ;
    logic [COUNTER_BITS-1:0] n_window;
    logic                    n_state;
    logic [COUNTER_BITS-1:0] w_stepped;

    always_comb begin
        // saturating integrator move
        if (i_level) begin
            w_stepped = (r_integ < i_target) ? r_integ + 1'b1 : r_integ;
        end else begin
            w_stepped = (r_integ != '0) ? r_integ - 1'b1 : r_integ;
        end

        o_result = '0;
        n_integ  = r_integ;
        n_window = r_window;
        n_state  = r_state;

        if (r_window < i_window) begin
            n_integ = w_stepped;
            if (!r_state && w_stepped == i_target) begin
                n_state                = 1'b1;
                n_window               = '0;
                o_result.pressed_event = 1'b1;
            end else if (r_state && w_stepped == '0) begin
                n_state                 = 1'b0;
                n_window                = '0;
                o_result.released_event = 1'b1;
            end else begin
                n_window               = r_window + 1'b1;
                o_result.keep_sampling = 1'b1;
            end
        end else begin
            // window ran out: snap to the limit of the current state
            n_integ                 = r_state ? i_target : '0;
            n_window                = '0;
            o_result.window_expired = 1'b1;
        end
        o_result.btn_down = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ  <= '0;
            r_window <= '0;
            r_state  <= 1'b0;
        end else if (i_step) begin
            r_integ  <= n_integ;
            r_window <= n_window;
            r_state  <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/windowed_integrator_debouncer_top.sv =====
// Windowed integrator debouncer. Each input word is one sample tick of the
// button pin; each tick gives exactly one result word with the press and
// release events, a request for another tick while unsettled, a flag for a
// tick that arrived after the settle window ran out, and the debounced state.
// A tick is registered on the input side, run through the combinational
// integrator and window logic, and the result is held in an output register.
// Throughput is one word per clock while i_out_ready does not stall the
// output; a result word passes the input register, then the output register.
// The integrator, window counter and state update in the cycle a tick
// leaves the input register. Registers: index 0 is the integrator target
// (reset 6), index 1 the window length in ticks (reset 15); other indexes
// are ignored. Both are saturated to the counter width when COUNTER_BITS is
// below 8. Write them only while no word is in flight.
`default_nettype none
module windowed_integrator_debouncer_top
    import wid_pkg::*;
#(
    parameter int COUNTER_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // sample input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_pin_level,
    // result output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_pressed_event,
    output logic                       o_released_event,
    output logic                       o_keep_sampling,
    output logic                       o_window_expired,
    output logic                       o_btn_down
);

    logic [COUNTER_BITS-1:0] w_target;
    logic [COUNTER_BITS-1:0] w_window;
    logic                    r_in_valid;
    logic                    r_in_pin;
    logic                    r_out_valid;
    t_result                 r_out;
    t_result                 w_result;
    logic                    w_step;

    // a held sample advances when the output register is free or draining
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    wid_cfg #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_target    (w_target),
        .o_window    (w_window)
    );

    wid_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_level  (r_in_pin),
        .i_target (w_target),
        .i_window (w_window),
        .o_result (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_pin <= i_pin_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pressed_event  = r_out.pressed_event;
    assign o_released_event = r_out.released_event;
    assign o_keep_sampling  = r_out.keep_sampling;
    assign o_window_expired = r_out.window_expired;
    assign o_btn_down       = r_out.btn_down;

endmodule
`default_nettype wire

// ===== rtl/wid_checker.sv =====
`default_nettype none
`include "windowed_integrator_debouncer_top_assert.svh"
module wid_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_pressed_event,
    input wire logic o_released_event,
    input wire logic o_keep_sampling,
    input wire logic o_window_expired,
    input wire logic o_btn_down
);

    logic [3:0] w_outcome;
    logic [4:0] w_word;

    assign w_outcome = {o_pressed_event, o_released_event, o_keep_sampling, o_window_expired};
    assign w_word    = {w_outcome, o_btn_down};

    // every result word reports exactly one outcome
    `WID_ASSERT_NOW(a_one_outcome, i_clk, i_rst_n, o_out_valid, $onehot(w_outcome),
                    "result word without exactly one outcome")

    // a press event leaves the button pressed
    `WID_ASSERT_NOW(a_press_state, i_clk, i_rst_n, o_out_valid && o_pressed_event, o_btn_down,
                    "press event with button released")

    // a release event leaves the button released
    `WID_ASSERT_NOW(a_release_state, i_clk, i_rst_n, o_out_valid && o_released_event,
                    !o_btn_down, "release event with button pressed")

    // a stalled result word holds
    `WID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                     o_out_valid && $stable(w_word), "stalled result word changed")

endmodule

bind windowed_integrator_debouncer_top wid_checker u_wid_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_pressed_event  (o_pressed_event),
    .o_released_event (o_released_event),
    .o_keep_sampling  (o_keep_sampling),
    .o_window_expired (o_window_expired),
    .o_btn_down       (o_btn_down)
);
`default_nettype wire
